FILE: rtl/core/svpwm_pkg.sv
// Shared constants, beat types and sector codes for the SVPWM compare pipeline.
package svpwm_pkg;

  localparam int FRAC_BITS = 15;
  localparam int IN_W      = 16;
  localparam int CNT_W     = 16;
  localparam int COEF_BITS = 30;
  localparam int SCALE_SH  = FRAC_BITS + COEF_BITS;
  localparam int XW        = IN_W + COEF_BITS + 1;
  localparam int SPLIT     = 24;
  localparam int HI_W      = XW - SPLIT;
  localparam int LO_PP_W   = SPLIT + CNT_W;
  localparam int HI_PP_W   = HI_W + CNT_W + 1;
  localparam int FULL_W    = 64;
  localparam int PW        = 20;
  localparam int SQ_W      = 2 * IN_W - 1;
  localparam int LATENCY   = 8;

  localparam logic [COEF_BITS-1:0] K_INV_SQRT3 = COEF_BITS'(619925131);
  localparam logic signed [FULL_W-1:0] RND_HALF = FULL_W'(64'sd1 <<< (SCALE_SH - 1));
  localparam logic [CNT_W-1:0] PERIOD_RST = CNT_W'(4096);

  localparam logic [2:0] SEC_1 = 3'd1;
  localparam logic [2:0] SEC_2 = 3'd2;
  localparam logic [2:0] SEC_3 = 3'd3;
  localparam logic [2:0] SEC_4 = 3'd4;
  localparam logic [2:0] SEC_5 = 3'd5;
  localparam logic [2:0] SEC_6 = 3'd6;

  typedef struct packed {
    logic                 valid;
    logic [2:0]           sector;
    logic signed [XW-1:0] xp;
    logic signed [XW-1:0] xq;
    logic [CNT_W-1:0]     per;
  } num_beat_t;

  typedef struct packed {
    logic                 valid;
    logic [2:0]           sector;
    logic signed [PW-1:0] p;
    logic signed [PW-1:0] q;
    logic [CNT_W-1:0]     per;
  } ont_beat_t;

endpackage

FILE: rtl/core/svpwm_alpha_beta_compare.sv
// Top level: period register and the eight-stage SVPWM compare pipeline.
// A vector taken at a start beat gives its result on done after the sector, scale and compare stages.
// Throughput: one vector per cycle; busy stays low, the pipeline never stalls.
// Reset (rst, synchronous): clears all valid bits and sets the period to 4096.
// Results are shown for one cycle only; the receiver has no way to hold them.
module svpwm_alpha_beta_compare import svpwm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [IN_W-1:0] alpha_rate,
  input  logic signed [IN_W-1:0] beta_rate,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CNT_W-1:0]       cfg_data,
  output logic                   done,
  output logic [2:0]             sector,
  output logic [CNT_W-1:0]       cmp_a,
  output logic [CNT_W-1:0]       cmp_b,
  output logic [CNT_W-1:0]       cmp_c
);

  logic [CNT_W-1:0] pwm_period;
  logic             accept;
  num_beat_t        num_beat;
  ont_beat_t        ont_beat;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period <= PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      pwm_period <= cfg_data;
    end
  end

  svpwm_sector u_sector (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (accept),
    .alpha_rate (alpha_rate),
    .beta_rate  (beta_rate),
    .period     (pwm_period),
    .num_q      (num_beat)
  );

  svpwm_scale u_scale (
    .clk   (clk),
    .rst   (rst),
    .num_d (num_beat),
    .ont_q (ont_beat)
  );

  svpwm_cmp u_cmp (
    .clk    (clk),
    .rst    (rst),
    .ont_d  (ont_beat),
    .done   (done),
    .sector (sector),
    .cmp_a  (cmp_a),
    .cmp_b  (cmp_b),
    .cmp_c  (cmp_c)
  );

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("accepted beat did not complete on time");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !accept |-> ##LATENCY !done)
    else $error("done without a matching accepted beat");

  a_sector_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (sector >= SEC_1 && sector <= SEC_6))
    else $error("sector out of range");
`endif

endmodule

FILE: rtl/core/svpwm_sector.sv
// Sector decision and on-time numerators (three register stages).
module svpwm_sector import svpwm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic signed [IN_W-1:0]  alpha_rate,
  input  logic signed [IN_W-1:0]  beta_rate,
  input  logic [CNT_W-1:0]        period,
  output num_beat_t               num_q
);

  logic                    v1;
  logic signed [IN_W-1:0]  a1;
  logic signed [IN_W-1:0]  b1;
  logic [CNT_W-1:0]        per1;

  logic signed [2*IN_W-1:0] asq;
  logic signed [2*IN_W-1:0] bsq;
  logic [SQ_W+1:0]          a2x3_next;
  logic signed [XW-1:0]     mb_next;

  logic                    v2;
  logic signed [IN_W-1:0]  a2;
  logic                    bneg2;
  logic [SQ_W+1:0]         a2x3;
  logic [SQ_W-1:0]         bsq2;
  logic signed [XW-1:0]    mb2;
  logic [CNT_W-1:0]        per2;

  logic                    apos;
  logic                    aneg;
  logic                    b_ge;
  logic                    b_le;
  logic [2:0]              sec;
  logic signed [XW-1:0]    ash;
  logic signed [XW-1:0]    mbx2;
  num_beat_t               num_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    a1   <= alpha_rate;
    b1   <= beta_rate;
    per1 <= period;
  end

  always_comb begin
    asq       = a1 * a1;
    bsq       = b1 * b1;
    a2x3_next = {2'b00, asq[SQ_W-1:0]} + {1'b0, asq[SQ_W-1:0], 1'b0};
    mb_next   = $signed({1'b0, K_INV_SQRT3}) * b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    a2    <= a1;
    bneg2 <= b1[IN_W-1];
    a2x3  <= a2x3_next;
    bsq2  <= bsq[SQ_W-1:0];
    mb2   <= mb_next;
    per2  <= per1;
  end

  always_comb begin
    aneg = a2[IN_W-1];
    apos = !a2[IN_W-1] && (a2 != '0);
    b_ge = {2'b00, bsq2} >= a2x3;
    b_le = {2'b00, bsq2} <= a2x3;
    if (!bneg2) begin
      if (apos)      sec = b_ge ? SEC_2 : SEC_1;
      else if (aneg) sec = b_le ? SEC_3 : SEC_2;
      else           sec = SEC_2;
    end else begin
      if (apos)      sec = b_le ? SEC_6 : SEC_5;
      else if (aneg) sec = b_ge ? SEC_5 : SEC_4;
      else           sec = SEC_5;
    end

    ash  = XW'(a2) <<< COEF_BITS;
    mbx2 = mb2 <<< 1;

    num_next        = '0;
    num_next.valid  = v2;
    num_next.sector = sec;
    num_next.per    = per2;
    unique case (sec)
      SEC_1: begin
        num_next.xp = ash - mb2;
        num_next.xq = mbx2;
      end
      SEC_2: begin
        num_next.xp = ash + mb2;
        num_next.xq = mb2 - ash;
      end
      SEC_3: begin
        num_next.xp = mbx2;
        num_next.xq = -ash - mb2;
      end
      SEC_4: begin
        num_next.xp = mb2 - ash;
        num_next.xq = -mbx2;
      end
      SEC_5: begin
        num_next.xp = -ash - mb2;
        num_next.xq = ash - mb2;
      end
      default: begin
        num_next.xp = -mbx2;
        num_next.xq = ash + mb2;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_q.valid <= 1'b0;
    end else begin
      num_q.valid <= num_next.valid;
    end
    num_q.sector <= num_next.sector;
    num_q.xp     <= num_next.xp;
    num_q.xq     <= num_next.xq;
    num_q.per    <= num_next.per;
  end

endmodule

FILE: rtl/core/svpwm_scale.sv
// Period scaling of the on-time numerators with round to nearest (two stages).
module svpwm_scale import svpwm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  num_beat_t num_d,
  output ont_beat_t ont_q
);

  logic                        v1;
  logic [2:0]                  sec1;
  logic [CNT_W-1:0]            per1;
  logic [LO_PP_W-1:0]          p_lo;
  logic [LO_PP_W-1:0]          q_lo;
  logic signed [HI_PP_W-1:0]   p_hi;
  logic signed [HI_PP_W-1:0]   q_hi;

  logic signed [FULL_W-1:0]    p_full;
  logic signed [FULL_W-1:0]    q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= num_d.valid;
    end
    sec1 <= num_d.sector;
    per1 <= num_d.per;
    p_lo <= num_d.xp[SPLIT-1:0] * num_d.per;
    q_lo <= num_d.xq[SPLIT-1:0] * num_d.per;
    p_hi <= $signed(num_d.xp[XW-1:SPLIT]) * $signed({1'b0, num_d.per});
    q_hi <= $signed(num_d.xq[XW-1:SPLIT]) * $signed({1'b0, num_d.per});
  end

  always_comb begin
    p_full = (FULL_W'(p_hi) <<< SPLIT) + $signed({{(FULL_W-LO_PP_W){1'b0}}, p_lo}) + RND_HALF;
    q_full = (FULL_W'(q_hi) <<< SPLIT) + $signed({{(FULL_W-LO_PP_W){1'b0}}, q_lo}) + RND_HALF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ont_q.valid <= 1'b0;
    end else begin
      ont_q.valid <= v1;
    end
    ont_q.sector <= sec1;
    ont_q.per    <= per1;
    ont_q.p      <= PW'(p_full >>> SCALE_SH);
    ont_q.q      <= PW'(q_full >>> SCALE_SH);
  end

endmodule

FILE: rtl/core/svpwm_cmp.sv
// Zero time split, running compare sums, clamp and phase mapping (three stages).
module svpwm_cmp import svpwm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  ont_beat_t        ont_d,
  output logic             done,
  output logic [2:0]       sector,
  output logic [CNT_W-1:0] cmp_a,
  output logic [CNT_W-1:0] cmp_b,
  output logic [CNT_W-1:0] cmp_c
);

  localparam int SW = PW + 3;

  logic                   v1;
  logic [2:0]             sec1;
  logic [CNT_W-1:0]       per1;
  logic signed [PW:0]     pq1;
  logic signed [PW-1:0]   first1;

  logic signed [SW-1:0]   diff;
  logic signed [SW-1:0]   z;

  logic                   v2;
  logic [2:0]             sec2;
  logic [CNT_W-1:0]       per2;
  logic signed [SW-1:0]   lo2;
  logic signed [SW-1:0]   mid2;
  logic signed [SW-1:0]   hi2;

  logic [CNT_W-1:0]       lo_c;
  logic [CNT_W-1:0]       mid_c;
  logic [CNT_W-1:0]       hi_c;

  function automatic logic [CNT_W-1:0] clamp_cnt(input logic signed [SW-1:0] v,
                                                  input logic [CNT_W-1:0] per);
    logic [CNT_W-1:0] r;
    if (v < 0) r = '0;
    else if (v > $signed({{(SW-CNT_W){1'b0}}, per})) r = per;
    else r = v[CNT_W-1:0];
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= ont_d.valid;
    end
    sec1   <= ont_d.sector;
    per1   <= ont_d.per;
    pq1    <= (PW+1)'(ont_d.p) + (PW+1)'(ont_d.q);
    first1 <= ont_d.sector[0] ? ont_d.q : ont_d.p;
  end

  always_comb begin
    diff = $signed({{(SW-CNT_W){1'b0}}, per1}) - SW'(pq1);
    z    = diff >>> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    sec2 <= sec1;
    per2 <= per1;
    lo2  <= z;
    mid2 <= z + SW'(first1);
    hi2  <= z + SW'(pq1);
  end

  always_comb begin
    lo_c  = clamp_cnt(lo2, per2);
    mid_c = clamp_cnt(mid2, per2);
    hi_c  = clamp_cnt(hi2, per2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v2;
    end
    sector <= sec2;
    unique case (sec2)
      SEC_1: begin
        cmp_a <= hi_c;  cmp_b <= mid_c; cmp_c <= lo_c;
      end
      SEC_2: begin
        cmp_a <= mid_c; cmp_b <= hi_c;  cmp_c <= lo_c;
      end
      SEC_3: begin
        cmp_a <= lo_c;  cmp_b <= hi_c;  cmp_c <= mid_c;
      end
      SEC_4: begin
        cmp_a <= lo_c;  cmp_b <= mid_c; cmp_c <= hi_c;
      end
      SEC_5: begin
        cmp_a <= mid_c; cmp_b <= lo_c;  cmp_c <= hi_c;
      end
      default: begin
        cmp_a <= hi_c;  cmp_b <= lo_c;  cmp_c <= mid_c;
      end
    endcase
  end

endmodule
